// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cse_enc_pkg.sv =====
// Types, character codes and helpers for the C string escape encoder.
// Used by c_string_escape_encoder_top; depends on nothing.
package cse_enc_pkg;

    localparam int CharW   = 16;
    localparam int RunMax  = 4;
    localparam int RunCntW = 3;

    typedef logic [CharW-1:0]   t_char;
    typedef logic [RunCntW-1:0] t_run_cnt;

    typedef struct packed {
        t_char in_char;
        logic  starts_string;
    } t_in_beat;

    typedef struct packed {
        t_char out_char;
        logic  last_of_run;
    } t_out_beat;

    // Control characters with a letter escape, and the space character
    localparam t_char C_BEL   = 16'h0007;
    localparam t_char C_BS    = 16'h0008;
    localparam t_char C_HT    = 16'h0009;
    localparam t_char C_LF    = 16'h000a;
    localparam t_char C_VT    = 16'h000b;
    localparam t_char C_FF    = 16'h000c;
    localparam t_char C_CR    = 16'h000d;
    localparam t_char C_SPACE = 16'h0020;
    // Printable characters used by the escapes
    localparam t_char C_DQUOTE = 16'h0022;
    localparam t_char C_SQUOTE = 16'h0027;
    localparam t_char C_BSLASH = 16'h005c;
    localparam t_char C_LOW_A  = 16'h0061;
    localparam t_char C_LOW_B  = 16'h0062;
    localparam t_char C_LOW_F  = 16'h0066;
    localparam t_char C_LOW_N  = 16'h006e;
    localparam t_char C_LOW_R  = 16'h0072;
    localparam t_char C_LOW_T  = 16'h0074;
    localparam t_char C_LOW_V  = 16'h0076;
    localparam t_char C_LOW_X  = 16'h0078;
    localparam t_char C_DIG_0  = 16'h0030;
    localparam t_char C_DIG_9  = 16'h0039;
    localparam t_char C_UP_A   = 16'h0041;
    localparam t_char C_UP_F   = 16'h0046;

    localparam t_run_cnt RUN_ONE  = 3'd1;
    localparam t_run_cnt RUN_PAIR = 3'd2;
    localparam t_run_cnt RUN_HEX  = 3'd4;

    function automatic logic is_hex_char(input t_char c);
        return ((c >= C_DIG_0) && (c <= C_DIG_9)) ||
               ((c >= C_LOW_A) && (c <= C_LOW_F)) ||
               ((c >= C_UP_A)  && (c <= C_UP_F));
    endfunction

    // Lowercase hex digit character for one nibble
    function automatic t_char hex_digit(input logic [3:0] nib);
        t_char d;
        if (nib < 4'd10) begin
            d = C_DIG_0 + t_char'(nib);
        end else begin
            d = C_LOW_A + t_char'(nib - 4'd10);
        end
        return d;
    endfunction

endpackage

// ===== rtl/c_string_escape_encoder_top.sv =====
// C string escape encoder: turns each wide input character into its escaped run.
// Depends on cse_enc_pkg and assert_macros.svh.
//
// Each input beat carries one character; the block answers with one, two or
// four output beats (the character itself, backslash plus letter, or \xHH),
// with last_of_run marking the final beat of the run. A hex flag, set by any
// \xHH escape and cleared by any other run or by starts_string, forces a
// directly following hex-digit character into \xHH too. Timing: an input
// beat lands in an input register, is encoded into the run register, and
// the run leaves one beat per cycle while i_stall is low. The run register
// emits one character a cycle when not stalled and so sets the throughput.
// The next item is encoded in the cycle the last beat of the current run is
// taken, so pass-through characters flow at one per cycle while i_stall is
// low. CHAR_WIDTH is the number of low input bits that form the character
// (at most 16 are used).
`include "assert_macros.svh"

module c_string_escape_encoder_top
    import cse_enc_pkg::*;
#(
    parameter int CHAR_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    // Character bits actually kept from the input field
    localparam int CodeW = (CHAR_WIDTH < CharW) ? CHAR_WIDTH : CharW;

    // Input register
    logic             r_in_valid;
    logic [CodeW-1:0] r_code;
    logic             r_start;

    // Run register: r_run[0] is the beat on the output
    t_char    r_run [RunMax];
    t_run_cnt r_cnt;
    logic     r_hex;

    logic     out_take;
    logic     in_take;
    logic     load;

    t_char    c;
    logic     flag;
    logic     is_pair;
    t_char    pair_ch;
    t_char    n_run [RunMax];
    t_run_cnt n_len;
    logic     n_hex;

    // Output beat comes straight off the run register
    assign o_valid          = (r_cnt != '0);
    assign o_data.out_char  = r_run[0];
    assign o_data.last_of_run = (r_cnt == RUN_ONE);
    assign out_take         = o_valid && !i_stall;

    // Encode the held item once the run register is free or frees this cycle
    assign load    = r_in_valid && ((r_cnt == '0) || ((r_cnt == RUN_ONE) && out_take));
    assign o_stall = r_in_valid && !load;
    assign in_take = i_valid && !o_stall;

    // Encoder: one pass from the input register to the next run
    always_comb begin
        c       = CharW'(r_code);
        flag    = r_start ? 1'b0 : r_hex;
        is_pair = 1'b1;
        pair_ch = C_BSLASH;
        unique case (c)
            C_BEL:    pair_ch = C_LOW_A;
            C_BS:     pair_ch = C_LOW_B;
            C_FF:     pair_ch = C_LOW_F;
            C_LF:     pair_ch = C_LOW_N;
            C_CR:     pair_ch = C_LOW_R;
            C_HT:     pair_ch = C_LOW_T;
            C_VT:     pair_ch = C_LOW_V;
            C_BSLASH: pair_ch = C_BSLASH;
            C_SQUOTE: pair_ch = C_SQUOTE;
            C_DQUOTE: pair_ch = C_DQUOTE;
            default:  is_pair = 1'b0;
        endcase

        n_run[0] = C_BSLASH;
        n_run[1] = pair_ch;
        n_run[2] = hex_digit(c[7:4]);
        n_run[3] = hex_digit(c[3:0]);
        priority if (is_pair) begin
            n_len = RUN_PAIR;
            n_hex = 1'b0;
        end else if ((flag && is_hex_char(c)) || (c < C_SPACE)) begin
            n_run[1] = C_LOW_X;
            n_len    = RUN_HEX;
            n_hex    = 1'b1;
        end else begin
            // Pass through unchanged
            n_run[0] = c;
            n_len    = RUN_ONE;
            n_hex    = 1'b0;
        end
    end

    // Input register: hold the beat until the encoder takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_code  <= i_data.in_char[CodeW-1:0];
            r_start <= i_data.starts_string;
        end
    end

    // Run register: load a new run, or advance by one beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hex <= 1'b0;
        end else if (load) begin
            r_cnt <= n_len;
            r_hex <= n_hex;
        end else if (out_take) begin
            r_cnt <= r_cnt - RUN_ONE;
        end
        if (load) begin
            r_run <= n_run;
        end else if (out_take) begin
            for (int k = 0; k < RunMax - 1; k++) begin
                r_run[k] <= r_run[k+1];
            end
        end
    end

    // A run never holds more than four beats
    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= RUN_HEX)
    // Every escape run opens with a backslash
    `ASSERT_NEXT(a_escape_lead, i_clk, i_rst_n, load && (n_len != RUN_ONE), r_run[0] == C_BSLASH)
    // An empty run register never holds off the input
    `ASSERT_ALWAYS(a_no_idle_stall, i_clk, i_rst_n, (r_cnt != '0) || !o_stall)
    // A four-beat run always leaves the hex flag set
    `ASSERT_NEXT(a_hex_flag, i_clk, i_rst_n, load && (n_len == RUN_HEX), r_hex)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for c_string_escape_encoder_top: a scoreboard class
// predicts each escaped run and checks it beat by beat against the output.
// Depends on cse_enc_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;
    import cse_enc_pkg::*;

    localparam int CharBits    = 16;
    localparam int RandomChars = 385;
    localparam int IdleLimit   = 1000;
    localparam int TailCycles  = 10;

    // Scoreboard: predicts the escaped run of every accepted character and
    // holds the output beats still owed by the encoder.
    class escape_scoreboard;
        t_out_beat owed_beats[$];
        bit        hex_pending;
        int        errors;

        function new();
            hex_pending = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        function void push_beat(t_char ch, logic last);
            t_out_beat b;
            b.out_char    = ch;
            b.last_of_run = last;
            owed_beats.push_back(b);
        endfunction

        function bit is_hex_symbol(t_char c);
            return ((c >= C_DIG_0) && (c <= C_DIG_9)) ||
                   ((c >= C_LOW_A) && (c <= C_LOW_F)) ||
                   ((c >= C_UP_A) && (c <= C_UP_F));
        endfunction

        function t_char nibble_symbol(logic [3:0] nib);
            if (nib < 4'd10) begin
                return C_DIG_0 + t_char'(nib);
            end
            return C_LOW_A + t_char'(nib - 4'd10);
        endfunction

        function void push_letter_escape(t_char letter);
            push_beat(C_BSLASH, 1'b0);
            push_beat(letter, 1'b1);
            hex_pending = 1'b0;
        endfunction

        function void push_hex_escape(t_char c);
            push_beat(C_BSLASH, 1'b0);
            push_beat(C_LOW_X, 1'b0);
            push_beat(nibble_symbol(c[7:4]), 1'b0);
            push_beat(nibble_symbol(c[3:0]), 1'b1);
            hex_pending = 1'b1;
        endfunction

        function void note_char_in(t_in_beat beat);
            t_char mask;
            t_char c;
            mask = t_char'((32'h1 << CharBits) - 1);
            c    = beat.in_char & mask;
            if (beat.starts_string) begin
                hex_pending = 1'b0;
            end
            case (c)
                C_BEL:    push_letter_escape(C_LOW_A);
                C_BS:     push_letter_escape(C_LOW_B);
                C_FF:     push_letter_escape(C_LOW_F);
                C_LF:     push_letter_escape(C_LOW_N);
                C_CR:     push_letter_escape(C_LOW_R);
                C_HT:     push_letter_escape(C_LOW_T);
                C_VT:     push_letter_escape(C_LOW_V);
                C_BSLASH: push_letter_escape(C_BSLASH);
                C_SQUOTE: push_letter_escape(C_SQUOTE);
                C_DQUOTE: push_letter_escape(C_DQUOTE);
                default: begin
                    if ((hex_pending && is_hex_symbol(c)) || (c < C_SPACE)) begin
                        push_hex_escape(c);
                    end else begin
                        push_beat(c, 1'b1);
                        hex_pending = 1'b0;
                    end
                end
            endcase
        endfunction

        function void check_char_out(t_out_beat got);
            t_out_beat want;
            if (owed_beats.size() == 0) begin
                $error("unexpected output beat: out_char %h last_of_run %b",
                       got.out_char, got.last_of_run);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %h, got %h", want.out_char, got.out_char);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %b, got %b",
                       want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_data;

    escape_scoreboard sb;
    bit               calm = 1'b0;   // no idling on either side while set
    int               idle_cycles = 0;

    c_string_escape_encoder_top #(
        .CHAR_WIDTH(CharBits)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #10 i_clk = ~i_clk;

    // Offer one character, after an optional random gap, and hold it until
    // the encoder takes the beat. Returns at the accepting edge.
    task automatic send_char(t_char ch, logic first);
        t_in_beat beat;
        int       gap;
        beat.in_char       = ch;
        beat.starts_string = first;
        gap = 0;
        if (!calm && ($urandom_range(0, 99) < 11)) begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.note_char_in(beat);
    endtask

    // Drop valid and hold off until every owed beat has come out. Polling on
    // the falling edge keeps the check clear of the monitor's rising edge.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Output side: check every accepted beat, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char_out(o_data);
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 11);
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int    n;
        int    pick;
        t_char ch;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero character at a string start, hex digits after a hex
        // escape in both cases, a breaking letter, every letter escape, a
        // letter escape clearing the flag, a string start clearing it, and
        // the extremes of the character code.
        send_char(16'h0000, 1'b1);
        send_char(C_DIG_0, 1'b0);
        send_char(C_UP_F, 1'b0);
        send_char(16'h0067, 1'b0);
        send_char(C_LOW_A, 1'b0);
        send_char(C_BEL, 1'b0);
        send_char(C_BS, 1'b0);
        send_char(C_HT, 1'b0);
        send_char(C_LF, 1'b0);
        send_char(C_VT, 1'b0);
        send_char(C_FF, 1'b0);
        send_char(C_CR, 1'b0);
        send_char(C_BSLASH, 1'b0);
        send_char(C_SQUOTE, 1'b0);
        send_char(C_DQUOTE, 1'b0);
        send_char(16'h001f, 1'b0);
        send_char(C_LF, 1'b0);
        send_char(C_DIG_9, 1'b0);
        send_char(16'h001b, 1'b0);
        send_char(16'h0063, 1'b1);
        send_char(16'hffff, 1'b0);
        send_char(16'h8000, 1'b1);
        send_char(C_SPACE, 1'b0);
        send_char(16'h0001, 1'b0);
        send_char(C_LOW_F, 1'b0);
        hold_until_drained();

        // Random strings: mostly control characters and hex digits so the
        // flag is exercised hard, plus quotes, backslashes, printable text and wide codes.
        for (n = 0; n < RandomChars; n++) begin
            calm = (n >= 150) && (n < 250);
            if (n == 300) begin
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                ch = t_char'($urandom_range(0, 31));
            end else if (pick < 55) begin
                case ($urandom_range(0, 2))
                    0: ch = C_DIG_0 + t_char'($urandom_range(0, 9));
                    1: ch = C_LOW_A + t_char'($urandom_range(0, 5));
                    default: ch = C_UP_A + t_char'($urandom_range(0, 5));
                endcase
            end else if (pick < 70) begin
                case ($urandom_range(0, 2))
                    0: ch = C_DQUOTE;
                    1: ch = C_SQUOTE;
                    default: ch = C_BSLASH;
                endcase
            end else if (pick < 90) begin
                ch = t_char'($urandom_range(32, 126));
            end else begin
                ch = t_char'($urandom_range(0, 65535));
            end
            send_char(ch, $urandom_range(0, 99) < 8);
        end
        calm = 1'b0;

        // Drain, then give a stray beat time to show up.
        hold_until_drained();
        repeat (TailCycles) @(posedge i_clk);
        if ((sb.errors == 0) && (sb.pending() == 0)) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
